// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl, all sampled on clk with arst_n low disabling them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfd assertion failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfd assertion failed");

`endif

// ===== hw/rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

	localparam logic [7:0] START_BYTE  = 8'h55;
	localparam logic [7:0] ESCAPE_BYTE = 8'hAA;
	localparam logic [7:0] ESC_CODE_55 = 8'h05;
	localparam logic [7:0] ESC_CODE_AA = 8'h0A;
	localparam logic [7:0] CRC_INIT    = 8'hFF;
	localparam logic [7:0] CRC_POLY    = 8'h1D;
	localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_PAY  = 2'd2,
		PH_CRC  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_GOOD    = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_ESCAPE = 2'd1,
		CAUSE_LENGTH = 2'd2,
		CAUSE_CRC    = 2'd3
	} cause_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] frame_len;
		cause_t     cause;
	} res_t;

endpackage

// ===== hw/rtl/sfd_crc8.sv =====
`timescale 1ns / 1ps

// one byte of crc-8, msb first
module sfd_crc8 (
	input  logic [7:0] crc_in,
	input  logic [7:0] byte_in,
	output logic [7:0] crc_out
);

	always_comb begin
		logic [7:0] c;
		c = crc_in ^ byte_in;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ sfd_pkg::CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// ===== hw/rtl/sfd_step.sv =====
`timescale 1ns / 1ps

// frame state and the per-item decode step
module sfd_step (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   rx_byte,
	input  logic [7:0]   max_length,
	output sfd_pkg::res_t res
);

	sfd_pkg::phase_t phase_q, phase_n;
	logic            esc_q, esc_n;
	logic [7:0]      crc_q, crc_n;
	logic [7:0]      count_q, count_n;
	logic [7:0]      exp_len_q, exp_len_n;
	logic [7:0]      crc_upd;
	logic [7:0]      ub;
	logic [7:0]      count_inc;
	logic            fail;
	sfd_pkg::cause_t fail_cause;

	sfd_crc8 u_crc (
		.crc_in  (crc_q),
		.byte_in (ub),
		.crc_out (crc_upd)
	);

	assign count_inc = count_q + 8'd1;

	// unstuffed byte
	always_comb begin
		ub = rx_byte;
		if (esc_q && rx_byte == sfd_pkg::ESC_CODE_55) begin
			ub = sfd_pkg::START_BYTE;
		end else if (esc_q && rx_byte == sfd_pkg::ESC_CODE_AA) begin
			ub = sfd_pkg::ESCAPE_BYTE;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		esc_n      = esc_q;
		crc_n      = crc_q;
		count_n    = count_q;
		exp_len_n  = exp_len_q;
		fail       = 1'b0;
		fail_cause = sfd_pkg::CAUSE_NONE;
		res        = '{kind: sfd_pkg::KIND_NONE, data: 8'd0, frame_len: 8'd0,
			cause: sfd_pkg::CAUSE_NONE};

		if (rx_byte == sfd_pkg::START_BYTE) begin
			// raw start byte always restarts, even over a pending escape
			phase_n   = sfd_pkg::PH_LEN;
			esc_n     = 1'b0;
			crc_n     = sfd_pkg::CRC_INIT;
			count_n   = 8'd0;
			exp_len_n = 8'd0;
		end else if (esc_q && rx_byte != sfd_pkg::ESC_CODE_55
			&& rx_byte != sfd_pkg::ESC_CODE_AA) begin
			fail       = 1'b1;
			fail_cause = sfd_pkg::CAUSE_ESCAPE;
		end else if (!esc_q && rx_byte == sfd_pkg::ESCAPE_BYTE) begin
			esc_n = 1'b1;
		end else begin
			esc_n = 1'b0;
			case (phase_q)
				sfd_pkg::PH_LEN: begin
					if (ub > max_length) begin
						fail       = 1'b1;
						fail_cause = sfd_pkg::CAUSE_LENGTH;
					end else begin
						exp_len_n = ub;
						count_n   = 8'd0;
						crc_n     = crc_upd;
						phase_n   = (ub != 8'd0) ? sfd_pkg::PH_PAY : sfd_pkg::PH_CRC;
					end
				end
				sfd_pkg::PH_PAY: begin
					crc_n   = crc_upd;
					count_n = count_inc;
					if (count_inc >= exp_len_q) begin
						phase_n = sfd_pkg::PH_CRC;
					end
					res.kind = sfd_pkg::KIND_PAYLOAD;
					res.data = ub;
				end
				sfd_pkg::PH_CRC: begin
					if (ub != crc_q) begin
						fail       = 1'b1;
						fail_cause = sfd_pkg::CAUSE_CRC;
					end else begin
						phase_n       = sfd_pkg::PH_HUNT;
						crc_n         = sfd_pkg::CRC_INIT;
						count_n       = 8'd0;
						exp_len_n     = 8'd0;
						res.kind      = sfd_pkg::KIND_GOOD;
						res.frame_len = exp_len_q;
					end
				end
				default: begin
					// hunting: ignore
				end
			endcase
		end

		if (fail) begin
			phase_n   = sfd_pkg::PH_HUNT;
			esc_n     = 1'b0;
			crc_n     = sfd_pkg::CRC_INIT;
			count_n   = 8'd0;
			exp_len_n = 8'd0;
			res.kind  = sfd_pkg::KIND_ERROR;
			res.data  = 8'd0;
			res.cause = fail_cause;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sfd_pkg::PH_HUNT;
			esc_q     <= 1'b0;
			crc_q     <= sfd_pkg::CRC_INIT;
			count_q   <= 8'd0;
			exp_len_q <= 8'd0;
		end else if (take) begin
			phase_q   <= phase_n;
			esc_q     <= esc_n;
			crc_q     <= crc_n;
			count_q   <= count_n;
			exp_len_q <= exp_len_n;
		end
	end

endmodule

// ===== hw/rtl/stuffed_frame_decoder.sv =====
`timescale 1ns / 1ps

// Byte-stuffed frame decoder with CRC-8 check. One stuffed link byte goes in per item and
// exactly one result item comes out for it: nothing, an unstuffed payload byte, frame good
// with its length, or an error with its cause. Throughput is one item per cycle while the
// output is not stalled; each item passes through the input register and then the decode step
// (unstuffing, one byte of CRC-8 and the phase update) into the result register, and the
// step's registered state update sets the rate. A raw 0x55 always restarts a frame; any
// error returns the decoder to hunting for a start byte. max_length is written through the
// configuration channel, which is always ready, and applies from the next length byte.
module stuffed_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data,
	output logic [7:0] frame_len,
	output logic [1:0] error_cause,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] max_length
);

	`include "assert_macros.svh"

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          out_valid_q;
	sfd_pkg::res_t res_q;
	sfd_pkg::res_t step_res;
	logic [7:0]    max_len_q;
	logic          out_free;
	logic          adv;

	assign out_free  = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= sfd_pkg::MAX_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	sfd_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (adv),
		.rx_byte    (byte_s1),
		.max_length (max_len_q),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = 2'(res_q.kind);
	assign data        = res_q.data;
	assign frame_len   = res_q.frame_len;
	assign error_cause = 2'(res_q.cause);

	// an item held in the input register is not dropped while the output is blocked
	`SFD_ASSERT_NEXT(a_s1_held, valid_s1 && !out_free, valid_s1)
	// a taken result with nothing behind it leaves the output empty
	`SFD_ASSERT_NEXT(a_out_drain, out_valid_q && !out_stall && !valid_s1, !out_valid_q)
	// an error result always carries a cause
	`SFD_ASSERT_IMP(a_err_cause, out_valid_q && res_q.kind == sfd_pkg::KIND_ERROR,
		res_q.cause != sfd_pkg::CAUSE_NONE)
	// a non-error result never carries a cause
	`SFD_ASSERT_IMP(a_no_cause, out_valid_q && res_q.kind != sfd_pkg::KIND_ERROR,
		res_q.cause == sfd_pkg::CAUSE_NONE)

endmodule

// ===== tb/sv/frame_check_pkg.sv =====
`timescale 1ns / 1ps

package frame_check_pkg;

	import sfd_pkg::*;

	// one step of the crc-8, msb first
	function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7])
				c = (c << 1) ^ CRC_POLY;
			else
				c = c << 1;
		end
		return c;
	endfunction

	class frame_scoreboard;
		res_t        due_results[$];
		phase_t      phase;
		bit          escape_seen;
		logic [7:0]  crc;
		logic [7:0]  payload_count;
		logic [7:0]  frame_length;
		logic [7:0]  length_limit;
		int unsigned failures;

		function new();
			length_limit = MAX_LENGTH_RESET;
			failures = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			phase = PH_HUNT;
			escape_seen = 1'b0;
			crc = CRC_INIT;
			payload_count = 8'd0;
			frame_length = 8'd0;
		endfunction

		function void set_length_limit(logic [7:0] v);
			length_limit = v;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// decode one raw link byte and queue the result it must give
		function void note_rx_byte(logic [7:0] raw);
			logic [7:0] b;
			res_t r;
			bit usable;
			b = raw;
			usable = 1'b1;
			r.kind = KIND_NONE;
			r.data = 8'h00;
			r.frame_len = 8'h00;
			r.cause = CAUSE_NONE;
			if (b == START_BYTE) begin
				// a raw start always restarts, pending escape or not
				clear_frame();
				phase = PH_LEN;
				usable = 1'b0;
			end else if (escape_seen) begin
				escape_seen = 1'b0;
				if (b == ESC_CODE_55) begin
					b = START_BYTE;
				end else if (b == ESC_CODE_AA) begin
					b = ESCAPE_BYTE;
				end else begin
					r.kind = KIND_ERROR;
					r.cause = CAUSE_ESCAPE;
					clear_frame();
					usable = 1'b0;
				end
			end else if (b == ESCAPE_BYTE) begin
				escape_seen = 1'b1;
				usable = 1'b0;
			end
			if (usable) begin
				case (phase)
					PH_LEN: begin
						if (b > length_limit) begin
							r.kind = KIND_ERROR;
							r.cause = CAUSE_LENGTH;
							clear_frame();
						end else begin
							frame_length = b;
							payload_count = 8'd0;
							crc = crc8_next(crc, b);
							if (b != 8'd0)
								phase = PH_PAY;
							else
								phase = PH_CRC;
						end
					end
					PH_PAY: begin
						crc = crc8_next(crc, b);
						payload_count = payload_count + 8'd1;
						if (payload_count >= frame_length)
							phase = PH_CRC;
						r.kind = KIND_PAYLOAD;
						r.data = b;
					end
					PH_CRC: begin
						if (b != crc) begin
							r.kind = KIND_ERROR;
							r.cause = CAUSE_CRC;
						end else begin
							r.kind = KIND_GOOD;
							r.frame_len = frame_length;
						end
						clear_frame();
					end
					default: ;
				endcase
			end
			due_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] k, logic [7:0] d, logic [7:0] len,
			logic [1:0] c);
			res_t e;
			if (due_results.size() == 0) begin
				$error("result item with nothing expected: kind %0d", k);
				failures++;
				return;
			end
			e = due_results.pop_front();
			if (k !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, k);
				failures++;
			end
			if (d !== e.data) begin
				$error("data: expected %02h, got %02h", e.data, d);
				failures++;
			end
			if (len !== e.frame_len) begin
				$error("frame_len: expected %0d, got %0d", e.frame_len, len);
				failures++;
			end
			if (c !== e.cause) begin
				$error("error_cause: expected %0d, got %0d", e.cause, c);
				failures++;
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	import sfd_pkg::*;
	import frame_check_pkg::*;

	localparam int ITEMS_PER_PHASE = 300;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_CYCLES     = 200;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int NUM_PHASES      = 6;

	typedef logic [7:0] octet_q_t[$];

	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_ESC,
		FR_TOO_LONG,
		FR_CUT,
		FR_NOISE
	} frame_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] data;
	logic [7:0] frame_len;
	logic [1:0] error_cause;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] max_length = 8'h00;

	logic hold_rx = 1'b0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   sent_items = 0;
	int   cur_max = 255;
	int   idle_cycles = 0;

	frame_scoreboard sb;

	stuffed_frame_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data(data),
		.frame_len(frame_len),
		.error_cause(error_cause),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_length(max_length)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= hold_rx || ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_rx_byte(rx_byte);
			if (out_valid && !out_stall)
				sb.check_result(kind, data, frame_len, error_cause);
		end
	end

	// counts cycles in which no handshake completes anywhere
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sent_items++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic send_stuffed(input logic [7:0] b);
		if (b == START_BYTE) begin
			send_byte(ESCAPE_BYTE);
			send_byte(ESC_CODE_55);
		end else if (b == ESCAPE_BYTE) begin
			send_byte(ESCAPE_BYTE);
			send_byte(ESC_CODE_AA);
		end else begin
			send_byte(b);
		end
	endtask

	// escape code that is neither legal nor a raw start
	function automatic logic [7:0] bad_code();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == ESC_CODE_55 || b == ESC_CODE_AA || b == START_BYTE);
		return b;
	endfunction

	function automatic logic [7:0] payload_octet();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return START_BYTE;
		else if (r == 1)
			return ESCAPE_BYTE;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic frame_mode_t pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return FR_GOOD;
		else if (r < 78)
			return FR_BAD_CRC;
		else if (r < 84)
			return FR_BAD_ESC;
		else if (r < 89)
			return FR_TOO_LONG;
		else if (r < 94)
			return FR_CUT;
		else
			return FR_NOISE;
	endfunction

	task automatic send_listed_frame(input octet_q_t payload, input bit spoil_crc);
		logic [7:0] crc;
		crc = crc8_next(CRC_INIT, 8'(payload.size()));
		send_byte(START_BYTE);
		send_stuffed(8'(payload.size()));
		foreach (payload[i]) begin
			crc = crc8_next(crc, payload[i]);
			send_stuffed(payload[i]);
		end
		if (spoil_crc)
			crc = crc ^ 8'h01;
		send_stuffed(crc);
	endtask

	task automatic send_frame(input frame_mode_t mode);
		logic [7:0] len;
		logic [7:0] crc;
		logic [7:0] b;
		int len_cap;
		int cut;
		int bad_at;
		if (mode == FR_NOISE) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			return;
		end
		send_byte(START_BYTE);
		if (mode == FR_TOO_LONG && cur_max < 255) begin
			send_stuffed(8'($urandom_range(cur_max + 1, 255)));
			return;
		end
		len_cap = (cur_max < 10) ? cur_max : 10;
		// a rare frame at the full limit, most kept short
		if ($urandom_range(0, 79) == 0)
			len = 8'(cur_max);
		else
			len = 8'($urandom_range(0, len_cap));
		crc = crc8_next(CRC_INIT, len);
		send_stuffed(len);
		cut = (mode == FR_CUT) ? $urandom_range(0, len) : -1;
		bad_at = (mode == FR_BAD_ESC) ? $urandom_range(0, len) : -1;
		for (int i = 0; i <= len; i++) begin
			if (i == cut)
				return;
			if (i == bad_at) begin
				send_byte(ESCAPE_BYTE);
				send_byte(bad_code());
				return;
			end
			if (i < len) begin
				b = payload_octet();
				crc = crc8_next(crc, b);
				send_stuffed(b);
			end
		end
		if (mode == FR_BAD_CRC)
			crc = crc ^ 8'($urandom_range(1, 255));
		send_stuffed(crc);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [7:0] v);
		cfg_valid <= 1'b1;
		max_length <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_length_limit(v);
		cur_max = v;
	endtask

	initial begin
		octet_q_t frame_bytes;
		int phase_max[NUM_PHASES];
		int phase_send_idle[NUM_PHASES];
		int phase_stall[NUM_PHASES];
		phase_max = '{0, 255, 1, -1, 254, 255};
		phase_send_idle = '{0, 49, 0, 25, 0, 0};
		phase_stall = '{0, 0, 49, 25, 0, 0};
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes ignored while hunting, bad escape while hunting
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(ESCAPE_BYTE);
		send_byte(8'h00);
		// escaped start while hunting does not open a frame
		send_byte(ESCAPE_BYTE);
		send_byte(ESC_CODE_55);
		// raw start with an escape pending, then an empty frame
		send_byte(ESCAPE_BYTE);
		send_byte(START_BYTE);
		send_stuffed(8'h00);
		send_stuffed(crc8_next(CRC_INIT, 8'h00));
		frame_bytes = {START_BYTE, ESCAPE_BYTE, 8'hFF};
		send_listed_frame(frame_bytes, 1'b0);
		// restart in the middle of the payload
		send_byte(START_BYTE);
		send_byte(8'h02);
		send_byte(8'h11);
		frame_bytes = {8'h00};
		send_listed_frame(frame_bytes, 1'b1);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_results_done();
			if (phase_max[ph] < 0)
				write_max_length(8'($urandom_range(2, 253)));
			else
				write_max_length(8'(phase_max[ph]));
			send_idle_pct = phase_send_idle[ph];
			stall_pct = phase_stall[ph];
			if (ph == 4) begin
				// long receiver hold-off so the decoder backs up into its input
				fork
					begin
						hold_rx <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_rx <= 1'b0;
					end
				join_none
			end
			sent_items = 0;
			while (sent_items < ITEMS_PER_PHASE)
				send_frame(pick_mode());
		end

		wait_results_done();
		if (sb.failures == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
